// File: rtl/rslf_pkg.sv
// Shared types and constants of the two-strip RGB linear fader.
// Used by rslf_step_div, rslf_lane and rgb_strip_linear_fader_top; no dependencies.
package rslf_pkg;

   localparam int DUR_W     = 16;
   localparam int COLOR_W   = 8;
   localparam int DUTY_W    = 16;
   localparam int FS_W      = 16;
   localparam int PERIOD_W  = 10;
   localparam int LANES     = 3;
   localparam int PROD_W    = COLOR_W + DUR_W;
   localparam int CNT_W     = $clog2(PROD_W);
   localparam int DPROD_W   = COLOR_W + FS_W;

   // Reciprocal of 255 scaled by 2**24, rounded down; one correction step follows.
   localparam int RECIP_W     = 17;
   localparam int RECIP_SHIFT = 24;
   localparam logic [RECIP_W-1:0] RECIP = 17'd65793;
   localparam logic [DPROD_W:0]   COLOR_FULL = 25'd255;

   localparam logic [FS_W-1:0]     FS_RESET     = 16'd4000;
   localparam logic [PERIOD_W-1:0] PERIOD_RESET = 10'd20;

   localparam logic [1:0] OP_SET  = 2'd0;
   localparam logic [1:0] OP_FADE = 2'd1;
   localparam logic [1:0] OP_TICK = 2'd2;

   localparam logic [1:0] SEL_BOTH = 2'd0;
   localparam logic [1:0] SEL_ONE  = 2'd1;
   localparam logic [1:0] SEL_TWO  = 2'd2;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic REG_FULL_SCALE  = 1'b0;
   localparam logic REG_STEP_PERIOD = 1'b1;

   typedef struct packed {
      logic load;
      logic iterate;
   } div_ctrl_type;

   typedef struct packed {
      logic load;
      logic iterate;
      logic take_color;
      logic use_target;
      logic mul;
      logic rcp;
      logic fix;
   } lane_ctrl_type;

endpackage

// File: rtl/rgb_strip_linear_fader_top.sv
// Top level of the two-strip RGB linear fader: sequencer, strip state, CSRs, result merge.
// Depends on rslf_pkg, rslf_step_div and rslf_lane (three lanes, one per color).
//
//   channel   direction  handshake               payload
//   req       in         req_valid / req_stall   opcode, red/green/blue_in, duration, select
//   rsp       out        rsp_valid / rsp_stall   duties, colors, strip flags, fade_finished
//   csr       in/out     APB psel/penable/pready duty_full_scale (0x0), step_period_ms (0x4)
//
// One beat is worked at a time; req_stall is high until its result sits in the output register.
// Set and final-target ticks run the color and duty stages; a fade tick first runs each
// lane's interpolation divider; a fade start runs the step-count divider, then the lane divider
// unless the fade has at most one step and lands on the target at once.
// Ticks while idle and unused opcodes send nothing. A held rsp beat delays only the next result.
// Reset is synchronous and clears strip colors, fade state and the CSRs to their defaults.
module rgb_strip_linear_fader_top (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [1:0]                      req_opcode,
   input  logic [rslf_pkg::COLOR_W-1:0]    req_red_in,
   input  logic [rslf_pkg::COLOR_W-1:0]    req_green_in,
   input  logic [rslf_pkg::COLOR_W-1:0]    req_blue_in,
   input  logic [rslf_pkg::DUR_W-1:0]      req_duration_ms,
   input  logic [1:0]                      req_strip_select,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [rslf_pkg::DUTY_W-1:0]     rsp_duty_red,
   output logic [rslf_pkg::DUTY_W-1:0]     rsp_duty_green,
   output logic [rslf_pkg::DUTY_W-1:0]     rsp_duty_blue,
   output logic [rslf_pkg::COLOR_W-1:0]    rsp_color_red,
   output logic [rslf_pkg::COLOR_W-1:0]    rsp_color_green,
   output logic [rslf_pkg::COLOR_W-1:0]    rsp_color_blue,
   output logic                            rsp_strip_one_updated,
   output logic                            rsp_strip_two_updated,
   output logic                            rsp_fade_finished,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [rslf_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [rslf_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [rslf_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                            csr_pready
);
   import rslf_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_STEP_DIV,
      ST_STEP_DONE,
      ST_DIV_LOAD,
      ST_LANE_DIV,
      ST_COLOR,
      ST_DUTY_MUL,
      ST_DUTY_RCP,
      ST_DUTY_FIX,
      ST_EMIT
   } state_type;

   state_type            state_ff;
   logic [CNT_W-1:0]     cnt_ff;
   logic                 fade_active_ff;
   logic [DUR_W-1:0]     total_ff;
   logic [DUR_W-1:0]     idx_ff;
   logic [1:0]           choice_ff;
   logic                 use_tgt_ff;
   logic                 finished_ff;
   logic [COLOR_W-1:0]   start_ff   [LANES];
   logic [COLOR_W-1:0]   target_ff  [LANES];
   logic [COLOR_W-1:0]   strip1_ff  [LANES];
   logic [COLOR_W-1:0]   strip2_ff  [LANES];
   logic [FS_W-1:0]      fs_ff;
   logic [PERIOD_W-1:0]  period_ff;

   logic                 rsp_valid_ff;
   logic [DUTY_W-1:0]    rsp_duty_ff  [LANES];
   logic [COLOR_W-1:0]   rsp_color_ff [LANES];
   logic                 rsp_one_ff;
   logic                 rsp_two_ff;
   logic                 rsp_fin_ff;

   logic                 req_accept;
   logic                 emit_go;
   logic                 csr_write;
   logic                 csr_index;
   logic                 sel_one;
   logic                 sel_two;
   logic                 req_from_one;
   logic [PERIOD_W-1:0]  divisor;
   logic [DUR_W-1:0]     step_quot;
   logic [COLOR_W-1:0]   req_color  [LANES];
   logic [COLOR_W-1:0]   lane_color [LANES];
   logic [DUTY_W-1:0]    lane_duty  [LANES];
   div_ctrl_type         step_ctrl;
   lane_ctrl_type        lane_ctrl;

   assign req_color[0] = req_red_in;
   assign req_color[1] = req_green_in;
   assign req_color[2] = req_blue_in;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign emit_go    = (state_ff == ST_EMIT) && (!rsp_valid_ff || !rsp_stall);

   assign sel_one      = (choice_ff == SEL_BOTH) || (choice_ff == SEL_ONE);
   assign sel_two      = (choice_ff == SEL_BOTH) || (choice_ff == SEL_TWO);
   assign req_from_one = (req_strip_select == SEL_BOTH) || (req_strip_select == SEL_ONE);

   // A zero step period behaves as one millisecond.
   assign divisor = (period_ff == '0) ? PERIOD_W'(1) : period_ff;

   // ---------------- configuration registers ----------------
   assign csr_pready = 1'b1;
   assign csr_index  = csr_paddr[CSR_ADDR_W-1];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_index == REG_STEP_PERIOD) ? CSR_DATA_W'(period_ff)
                                                      : CSR_DATA_W'(fs_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         fs_ff     <= FS_RESET;
         period_ff <= PERIOD_RESET;
      end else if (csr_write) begin
         if (csr_index == REG_FULL_SCALE) begin
            fs_ff <= csr_pwdata[FS_W-1:0];
         end else begin
            period_ff <= csr_pwdata[PERIOD_W-1:0];
         end
      end
   end

   // ---------------- datapath units ----------------
   always_comb begin
      step_ctrl.load    = req_accept && (req_opcode == OP_FADE);
      step_ctrl.iterate = (state_ff == ST_STEP_DIV);

      lane_ctrl.load       = (state_ff == ST_DIV_LOAD);
      lane_ctrl.iterate    = (state_ff == ST_LANE_DIV);
      lane_ctrl.take_color = (state_ff == ST_COLOR);
      lane_ctrl.use_target = use_tgt_ff;
      lane_ctrl.mul        = (state_ff == ST_DUTY_MUL);
      lane_ctrl.rcp        = (state_ff == ST_DUTY_RCP);
      lane_ctrl.fix        = (state_ff == ST_DUTY_FIX);
   end

   rslf_step_div u_step_div (
      .clock    (clock),
      .ctrl     (step_ctrl),
      .dividend (req_duration_ms),
      .divisor  (divisor),
      .quotient (step_quot)
   );

   for (genvar l = 0; l < LANES; l++) begin : g_lane
      rslf_lane u_lane (
         .clock        (clock),
         .ctrl         (lane_ctrl),
         .start_color  (start_ff[l]),
         .target_color (target_ff[l]),
         .step_index   (idx_ff),
         .step_total   (total_ff),
         .full_scale   (fs_ff),
         .color        (lane_color[l]),
         .duty         (lane_duty[l])
      );
   end

   // ---------------- sequencer and fade state ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         cnt_ff         <= '0;
         fade_active_ff <= 1'b0;
         total_ff       <= '0;
         idx_ff         <= '0;
         choice_ff      <= SEL_BOTH;
         use_tgt_ff     <= 1'b0;
         finished_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         for (int l = 0; l < LANES; l++) begin
            start_ff[l]  <= '0;
            target_ff[l] <= '0;
            strip1_ff[l] <= '0;
            strip2_ff[l] <= '0;
         end
      end else begin
         if (emit_go) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end

         case (state_ff)
            ST_IDLE: begin
               if (req_accept) begin
                  case (req_opcode)
                     OP_SET: begin
                        // The target registers carry the set color; no fade reads them
                        // again before the next fade command rewrites them.
                        fade_active_ff <= 1'b0;
                        choice_ff      <= req_strip_select;
                        use_tgt_ff     <= 1'b1;
                        finished_ff    <= 1'b0;
                        for (int l = 0; l < LANES; l++) begin
                           target_ff[l] <= req_color[l];
                        end
                        state_ff <= ST_COLOR;
                     end
                     OP_FADE: begin
                        fade_active_ff <= 1'b0;
                        choice_ff      <= req_strip_select;
                        for (int l = 0; l < LANES; l++) begin
                           target_ff[l] <= req_color[l];
                           start_ff[l]  <= req_from_one ? strip1_ff[l] : strip2_ff[l];
                        end
                        cnt_ff   <= CNT_W'(DUR_W - 1);
                        state_ff <= ST_STEP_DIV;
                     end
                     OP_TICK: begin
                        if (fade_active_ff) begin
                           if (idx_ff < total_ff - 1'b1) begin
                              use_tgt_ff  <= 1'b0;
                              finished_ff <= 1'b0;
                              state_ff    <= ST_DIV_LOAD;
                           end else begin
                              fade_active_ff <= 1'b0;
                              use_tgt_ff     <= 1'b1;
                              finished_ff    <= 1'b1;
                              state_ff       <= ST_COLOR;
                           end
                        end
                     end
                     default: begin
                     end
                  endcase
               end
            end
            ST_STEP_DIV: begin
               cnt_ff <= cnt_ff - 1'b1;
               if (cnt_ff == '0) begin
                  state_ff <= ST_STEP_DONE;
               end
            end
            ST_STEP_DONE: begin
               total_ff <= step_quot;
               idx_ff   <= '0;
               // Fades of zero or one step jump straight to the target.
               if (step_quot <= DUR_W'(1)) begin
                  use_tgt_ff  <= 1'b1;
                  finished_ff <= 1'b1;
                  state_ff    <= ST_COLOR;
               end else begin
                  fade_active_ff <= 1'b1;
                  use_tgt_ff     <= 1'b0;
                  finished_ff    <= 1'b0;
                  state_ff       <= ST_DIV_LOAD;
               end
            end
            ST_DIV_LOAD: begin
               cnt_ff   <= CNT_W'(PROD_W - 1);
               state_ff <= ST_LANE_DIV;
            end
            ST_LANE_DIV: begin
               cnt_ff <= cnt_ff - 1'b1;
               if (cnt_ff == '0) begin
                  state_ff <= ST_COLOR;
               end
            end
            ST_COLOR: begin
               if (!use_tgt_ff) begin
                  idx_ff <= idx_ff + 1'b1;
               end
               state_ff <= ST_DUTY_MUL;
            end
            ST_DUTY_MUL: begin
               state_ff <= ST_DUTY_RCP;
            end
            ST_DUTY_RCP: begin
               state_ff <= ST_DUTY_FIX;
            end
            ST_DUTY_FIX: begin
               state_ff <= ST_EMIT;
            end
            ST_EMIT: begin
               if (emit_go) begin
                  for (int l = 0; l < LANES; l++) begin
                     if (sel_one) begin
                        strip1_ff[l] <= lane_color[l];
                     end
                     if (sel_two) begin
                        strip2_ff[l] <= lane_color[l];
                     end
                  end
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   // ---------------- result register (merge of the lanes) ----------------
   always_ff @(posedge clock) begin
      if (emit_go) begin
         for (int l = 0; l < LANES; l++) begin
            rsp_duty_ff[l]  <= lane_duty[l];
            rsp_color_ff[l] <= lane_color[l];
         end
         rsp_one_ff <= sel_one;
         rsp_two_ff <= sel_two;
         rsp_fin_ff <= finished_ff;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_duty_red          = rsp_duty_ff[0];
   assign rsp_duty_green        = rsp_duty_ff[1];
   assign rsp_duty_blue         = rsp_duty_ff[2];
   assign rsp_color_red         = rsp_color_ff[0];
   assign rsp_color_green       = rsp_color_ff[1];
   assign rsp_color_blue        = rsp_color_ff[2];
   assign rsp_strip_one_updated = rsp_one_ff;
   assign rsp_strip_two_updated = rsp_two_ff;
   assign rsp_fade_finished     = rsp_fin_ff;

`ifndef NO_ASSERTIONS
   a_fade_bounds: assert property (@(posedge clock) disable iff (reset)
      fade_active_ff |-> (total_ff >= DUR_W'(2) && idx_ff < total_ff))
      else $error("active fade with step index outside its step count");

   a_emit_lands: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT && !rsp_valid_ff) |=> (rsp_valid_ff && state_ff == ST_IDLE))
      else $error("result not placed in an empty output register");

   a_set_direct: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_opcode == OP_SET) |=> (state_ff == ST_COLOR && use_tgt_ff
                                                && !fade_active_ff))
      else $error("set beat did not go straight to the color stage");
`endif

endmodule

// File: rtl/rslf_step_div.sv
// Radix-2 restoring divider that turns a fade duration into a step count.
// Depends on rslf_pkg; sequenced by the top level, one quotient bit per cycle.
module rslf_step_div (
   input  logic                          clock,
   input  rslf_pkg::div_ctrl_type        ctrl,
   input  logic [rslf_pkg::DUR_W-1:0]    dividend,
   input  logic [rslf_pkg::PERIOD_W-1:0] divisor,
   output logic [rslf_pkg::DUR_W-1:0]    quotient
);
   import rslf_pkg::*;

   logic [PERIOD_W-1:0] rem_ff;
   logic [DUR_W-1:0]    quo_ff;
   logic [PERIOD_W:0]   shifted;
   logic [PERIOD_W+1:0] trial;

   assign shifted = {rem_ff, quo_ff[DUR_W-1]};
   assign trial   = {1'b0, shifted} - {2'b00, divisor};

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         rem_ff <= '0;
         quo_ff <= dividend;
      end else if (ctrl.iterate) begin
         if (!trial[PERIOD_W+1]) begin
            rem_ff <= trial[PERIOD_W-1:0];
         end else begin
            rem_ff <= shifted[PERIOD_W-1:0];
         end
         quo_ff <= {quo_ff[DUR_W-2:0], ~trial[PERIOD_W+1]};
      end
   end

   assign quotient = quo_ff;

endmodule

// File: rtl/rslf_lane.sv
// One color lane: interpolates start to target at a step index, then scales to a duty.
// Depends on rslf_pkg; three copies run in lockstep under the top-level sequencer.
module rslf_lane (
   input  logic                         clock,
   input  rslf_pkg::lane_ctrl_type      ctrl,
   input  logic [rslf_pkg::COLOR_W-1:0] start_color,
   input  logic [rslf_pkg::COLOR_W-1:0] target_color,
   input  logic [rslf_pkg::DUR_W-1:0]   step_index,
   input  logic [rslf_pkg::DUR_W-1:0]   step_total,
   input  logic [rslf_pkg::FS_W-1:0]    full_scale,
   output logic [rslf_pkg::COLOR_W-1:0] color,
   output logic [rslf_pkg::DUTY_W-1:0]  duty
);
   import rslf_pkg::*;

   logic                         neg_ff;
   logic [DUR_W-1:0]             rem_ff;
   logic [PROD_W-1:0]            quo_ff;
   logic [COLOR_W-1:0]           color_ff;
   logic [DPROD_W-1:0]           mul_ff;
   logic [RECIP_W-1:0]           est_ff;
   logic [DUTY_W-1:0]            duty_ff;

   logic [COLOR_W:0]             diff;
   logic [COLOR_W:0]             neg_diff;
   logic [COLOR_W-1:0]           mag;
   logic [DUR_W:0]               shifted;
   logic [DUR_W+1:0]             trial;
   logic [COLOR_W-1:0]           quot;
   logic [COLOR_W-1:0]           color_in;
   logic [RECIP_W+DPROD_W-1:0]   rcp_prod;
   logic [DPROD_W:0]             est_x255;
   logic [DPROD_W:0]             resid;
   logic [RECIP_W-1:0]           est_inc;

   assign diff     = {1'b0, target_color} - {1'b0, start_color};
   assign neg_diff = -diff;
   assign mag      = diff[COLOR_W] ? neg_diff[COLOR_W-1:0] : diff[COLOR_W-1:0];

   assign shifted  = {rem_ff, quo_ff[PROD_W-1]};
   assign trial    = {1'b0, shifted} - {2'b00, step_total};

   // The quotient never exceeds the color difference, so its low byte is all of it.
   assign quot     = quo_ff[COLOR_W-1:0];
   assign color_in = ctrl.use_target ? target_color
                   : (neg_ff ? start_color - quot : start_color + quot);

   assign rcp_prod = (RECIP_W+DPROD_W)'(mul_ff) * (RECIP_W+DPROD_W)'(RECIP);
   assign est_x255 = {est_ff, COLOR_W'(0)} - (DPROD_W+1)'(est_ff);
   assign resid    = {1'b0, mul_ff} - est_x255;
   assign est_inc  = est_ff + 1'b1;

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         neg_ff <= diff[COLOR_W];
         rem_ff <= '0;
         quo_ff <= PROD_W'(mag) * PROD_W'(step_index);
      end else if (ctrl.iterate) begin
         if (!trial[DUR_W+1]) begin
            rem_ff <= trial[DUR_W-1:0];
         end else begin
            rem_ff <= shifted[DUR_W-1:0];
         end
         quo_ff <= {quo_ff[PROD_W-2:0], ~trial[DUR_W+1]};
      end
      if (ctrl.take_color) begin
         color_ff <= color_in;
      end
      if (ctrl.mul) begin
         mul_ff <= DPROD_W'(color_ff) * DPROD_W'(full_scale);
      end
      if (ctrl.rcp) begin
         est_ff <= rcp_prod[RECIP_SHIFT +: RECIP_W];
      end
      // The estimate is at most one below the true quotient.
      if (ctrl.fix) begin
         if (resid >= COLOR_FULL) begin
            duty_ff <= est_inc[DUTY_W-1:0];
         end else begin
            duty_ff <= est_ff[DUTY_W-1:0];
         end
      end
   end

   assign color = color_ff;
   assign duty  = duty_ff;

endmodule
